// ===== rtl/mqsb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_pkg: shared types and constants of the multi-queue shared buffer
// Field widths, result codes, default sizes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package mqsb_pkg;

   // item field widths
   localparam int CMD_W     = 1;
   localparam int QID_W     = 3;
   localparam int IO_DATA_W = 32;
   localparam int STATUS_W  = 2;

   // default sizes
   localparam int NUM_SLOTS_DEF  = 64;
   localparam int NUM_QUEUES_DEF = 8;
   localparam int DATA_WIDTH_DEF = 32;

   // operation codes
   localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
   localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

   // result codes
   localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the accepted item
      logic rd_q;     // read queue head/tail and the free-list link
      logic rd_s;     // read link and data of the head slot
      logic commit;   // write back state and load the result register
   } mqsb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic deq;      // captured item is a dequeue
      logic out_free; // result register can take a new item
   } mqsb_sts_type;

endpackage

// ===== rtl/mqsb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents not reset.
// ----------------------------------------------------------------------------
module mqsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mqsb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_ctrl: operation sequencer
// Steps one item through capture, queue read, slot read (dequeues only) and write-back.
// ----------------------------------------------------------------------------
module mqsb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mqsb_pkg::mqsb_sts_type sts,
   output mqsb_pkg::mqsb_cmd_type cmd
);
   import mqsb_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD_Q = 2'd1;
   localparam logic [1:0] S_RD_S = 2'd2;
   localparam logic [1:0] S_EXEC = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RD_Q;
            end
         end
         S_RD_Q: begin
            cmd.rd_q = 1'b1;
            state_in = sts.deq ? S_RD_S : S_EXEC;
         end
         S_RD_S: begin
            cmd.rd_s = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // hold until the result register frees up
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/mqsb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_datapath: slot store, queue pointers, free list and result register
// Holds the captured item, the four RAMs, the free-list head and the
// fresh-slot counter, and computes the write-back of one operation.
// ----------------------------------------------------------------------------
module mqsb_datapath #(
   parameter int NUM_SLOTS  = mqsb_pkg::NUM_SLOTS_DEF,
   parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
   parameter int DATA_WIDTH = mqsb_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [mqsb_pkg::CMD_W-1:0]           req_cmd,
   input  logic [mqsb_pkg::QID_W-1:0]           req_queue_id,
   input  logic signed [mqsb_pkg::IO_DATA_W-1:0] req_data_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mqsb_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [mqsb_pkg::IO_DATA_W-1:0] rsp_data_out,
   input  mqsb_pkg::mqsb_cmd_type               cmd,
   output mqsb_pkg::mqsb_sts_type               sts
);
   import mqsb_pkg::*;

   localparam int PW = $clog2(NUM_SLOTS + 1);                  // pointer incl. null
   localparam int SW = $clog2(NUM_SLOTS);                      // slot index
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam logic [PW-1:0] LINK_NULL = PW'(NUM_SLOTS);

   // captured item
   logic [CMD_W-1:0]      cmd_ff;
   logic [QID_W-1:0]      qid_ff;
   logic [DATA_WIDTH-1:0] din_ff;

   // pointer state
   logic [NUM_QUEUES-1:0] head_vld_ff;
   logic [NUM_QUEUES-1:0] head_vld_in;
   logic [PW-1:0]         free_head_ff;
   logic [PW-1:0]         free_head_in;
   logic [PW-1:0]         fresh_ff;
   logic [PW-1:0]         fresh_in;

   // result register
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic [IO_DATA_W-1:0]  data_out_ff;
   logic [STATUS_W-1:0]   status_in;
   logic [IO_DATA_W-1:0]  data_out_in;

   // RAM ports
   logic [SW-1:0]         head_rd;
   logic [SW-1:0]         tail_rd;
   logic [PW-1:0]         link_rd;
   logic [DATA_WIDTH-1:0] data_rd;
   logic                  head_we;
   logic [SW-1:0]         head_wdata;
   logic                  link_we;
   logic [SW-1:0]         link_waddr;
   logic [PW-1:0]         link_wdata;
   logic [SW-1:0]         link_raddr;

   // decode
   logic [QW-1:0]         qidx;
   logic                  q_ok;
   logic                  full;
   logic                  hv;
   logic                  enq_ok;
   logic                  deq_ok;
   logic                  from_fresh;
   logic                  is_last;
   logic [PW-1:0]         next_free;
   logic [SW-1:0]         alloc_slot;

   assign qidx       = QW'(qid_ff);
   assign q_ok       = 32'(qid_ff) < 32'(NUM_QUEUES);
   assign full       = free_head_ff == LINK_NULL;
   assign hv         = q_ok && head_vld_ff[qidx];
   assign enq_ok     = (cmd_ff == CMD_ENQ) && q_ok && !full;
   assign deq_ok     = (cmd_ff == CMD_DEQ) && hv;
   // slots at or above the fresh mark were never written; their link is taken as i+1
   assign from_fresh = free_head_ff >= fresh_ff;
   assign next_free  = from_fresh ? (free_head_ff + PW'(1)) : link_rd;
   assign alloc_slot = free_head_ff[SW-1:0];
   assign is_last    = head_rd == tail_rd;

   assign sts.deq      = cmd_ff == CMD_DEQ;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         qid_ff <= req_queue_id;
         din_ff <= DATA_WIDTH'(req_data_in);
      end
   end

   // head RAM write: first slot of an empty queue, or the successor on dequeue
   assign head_we    = cmd.commit && ((enq_ok && !hv) || (deq_ok && !is_last));
   assign head_wdata = deq_ok ? link_rd[SW-1:0] : alloc_slot;

   // link RAM: append after tail on enqueue, push to free list on dequeue
   assign link_we    = cmd.commit && ((enq_ok && hv) || deq_ok);
   assign link_waddr = deq_ok ? head_rd : tail_rd;
   assign link_wdata = deq_ok ? free_head_ff : PW'(alloc_slot);
   assign link_raddr = cmd.rd_s ? head_rd : alloc_slot;

   mqsb_ram #(.WIDTH(SW), .DEPTH(NUM_QUEUES)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (qidx),
      .wr_data (head_wdata),
      .rd_en   (cmd.rd_q),
      .rd_addr (qidx),
      .rd_data (head_rd)
   );

   mqsb_ram #(.WIDTH(SW), .DEPTH(NUM_QUEUES)) u_tail_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && enq_ok),
      .wr_addr (qidx),
      .wr_data (alloc_slot),
      .rd_en   (cmd.rd_q),
      .rd_addr (qidx),
      .rd_data (tail_rd)
   );

   mqsb_ram #(.WIDTH(PW), .DEPTH(NUM_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (cmd.rd_q || cmd.rd_s),
      .rd_addr (link_raddr),
      .rd_data (link_rd)
   );

   mqsb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_SLOTS)) u_data_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && enq_ok),
      .wr_addr (alloc_slot),
      .wr_data (din_ff),
      .rd_en   (cmd.rd_s),
      .rd_addr (head_rd),
      .rd_data (data_rd)
   );

   // pointer write-back
   always_comb begin
      head_vld_in  = head_vld_ff;
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      if (cmd.commit && enq_ok) begin
         free_head_in = next_free;
         if (from_fresh) begin
            fresh_in = fresh_ff + PW'(1);
         end
         if (!hv) begin
            head_vld_in[qidx] = 1'b1;
         end
      end
      if (cmd.commit && deq_ok) begin
         free_head_in = PW'(head_rd);
         if (is_last) begin
            head_vld_in[qidx] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff  <= '0;
         free_head_ff <= '0;
         fresh_ff     <= '0;
      end else begin
         head_vld_ff  <= head_vld_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
      end
   end

   // result
   always_comb begin
      if (cmd_ff == CMD_ENQ) begin
         status_in   = enq_ok ? ST_ENQUEUED : ST_FULL;
         data_out_in = '0;
      end else begin
         status_in   = deq_ok ? ST_DEQUEUED : ST_EMPTY;
         data_out_in = deq_ok ? IO_DATA_W'($signed(data_rd)) : '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff   <= status_in;
         data_out_ff <= data_out_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_data_out = data_out_ff;

endmodule

// ===== rtl/multi_queue_shared_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer: FIFO queues sharing one linked slot store
// NUM_QUEUES queues draw slots from one store of NUM_SLOTS entries through a
// linked free list; each slot keeps a data word and a next-slot link.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ------------------------------
//  req_      in         req_valid / req_ready  req_cmd, req_queue_id,
//                                              req_data_in
//  rsp_      out        rsp_valid / rsp_ready  rsp_status, rsp_data_out
//
//  Sequence: one item at a time. An enqueue or a full answer steps through
//  accept, head/tail RAM read and write-back; a dequeue or an empty answer
//  adds a slot link/data RAM read before the write-back.
//  Reset: no clearing pass. A fresh-slot counter stands in for the reset
//  links of the store, so items are taken right after reset.
//  Stalls: a finished result waits in the output register; a new item is
//  accepted meanwhile, and its write-back holds until that result is taken.
//
module multi_queue_shared_buffer #(
   parameter int NUM_SLOTS  = mqsb_pkg::NUM_SLOTS_DEF,
   parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
   parameter int DATA_WIDTH = mqsb_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [mqsb_pkg::CMD_W-1:0]           req_cmd,
   input  logic [mqsb_pkg::QID_W-1:0]           req_queue_id,
   input  logic signed [mqsb_pkg::IO_DATA_W-1:0] req_data_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mqsb_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [mqsb_pkg::IO_DATA_W-1:0] rsp_data_out
);
   import mqsb_pkg::*;

   // sequencer commands and datapath status
   mqsb_cmd_type cmd;
   mqsb_sts_type sts;

   // the controller walks each item through its read and write-back steps
   mqsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // the datapath owns every RAM, pointer and the result register
   mqsb_datapath #(
      .NUM_SLOTS  (NUM_SLOTS),
      .NUM_QUEUES (NUM_QUEUES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_cmd      (req_cmd),
      .req_queue_id (req_queue_id),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule

// ===== rtl/mqsb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_checker: port-level checks of the multi-queue shared buffer
// Watches both channels and flags result and sequencing violations.
// ----------------------------------------------------------------------------
module mqsb_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [mqsb_pkg::STATUS_W-1:0]        rsp_status,
   input logic signed [mqsb_pkg::IO_DATA_W-1:0] rsp_data_out
);
   import mqsb_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                 && $stable(rsp_data_out))
      else $error("result changed while stalled");

   // enqueue answers carry zero data
   a_enq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ENQUEUED || rsp_status == ST_FULL)
         |-> rsp_data_out == '0)
      else $error("enqueue result with nonzero data");

   // empty answers carry all ones
   a_empty_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_data_out == '1)
      else $error("empty result without all-ones data");

   // one item in flight: no accept right after an accept
   a_no_b2b: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous one in flight");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_data_out (rsp_data_out)
);

// ===== dv/mqsb_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_scoreboard: reply predictor and checker for the shared-buffer queues
// Tracks its own copy of the slot store, the free list and the queue
// head/tail pointers, predicts one reply per accepted request item and
// compares every accepted reply item, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module mqsb_scoreboard
   import mqsb_pkg::*;
#(
   parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
   parameter int NUM_QUEUES = NUM_QUEUES_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [CMD_W-1:0]            req_cmd,
   input  logic [QID_W-1:0]            req_queue_id,
   input  logic signed [IO_DATA_W-1:0] req_data_in,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [STATUS_W-1:0]         rsp_status,
   input  logic signed [IO_DATA_W-1:0] rsp_data_out,
   output int                          mismatch_count,
   output int                          outstanding
);

   localparam int LINK_W = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_SLOTS);

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [IO_DATA_W-1:0] data_out;
   } reply_type;

   logic [DATA_WIDTH-1:0] slot_word [NUM_SLOTS];
   logic [LINK_W-1:0]     slot_next [NUM_SLOTS];
   logic [LINK_W-1:0]     head_of [NUM_QUEUES];
   logic [LINK_W-1:0]     tail_of [NUM_QUEUES];
   logic [LINK_W-1:0]     free_slot;
   reply_type             predicted_replies [$];

   // chain every slot into the free list, all queues empty
   function void clear_store();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_word[i] = '0;
         slot_next[i] = LINK_W'(i + 1);
      end
      for (int q = 0; q < NUM_QUEUES; q++) begin
         head_of[q] = LINK_NULL;
         tail_of[q] = LINK_NULL;
      end
      free_slot = '0;
   endfunction

   function reply_type apply_queue_op(input logic [CMD_W-1:0]     cmd,
                                      input logic [QID_W-1:0]     qid,
                                      input logic [IO_DATA_W-1:0] din);
      reply_type         r;
      logic [LINK_W-1:0] slot;
      logic [SLOT_W-1:0] sidx;
      if (cmd == CMD_ENQ) begin
         r.data_out = '0;
         if (int'(qid) >= NUM_QUEUES || int'(free_slot) >= NUM_SLOTS) begin
            r.status = ST_FULL;
            return r;
         end
         slot      = free_slot;
         sidx      = slot[SLOT_W-1:0];
         free_slot = slot_next[sidx];
         // a drained queue keeps a stale tail; a null head overrides it
         if (int'(head_of[qid]) >= NUM_SLOTS)
            head_of[qid] = slot;
         else if (int'(tail_of[qid]) < NUM_SLOTS)
            slot_next[tail_of[qid][SLOT_W-1:0]] = slot;
         slot_next[sidx] = LINK_NULL;
         tail_of[qid]    = slot;
         slot_word[sidx] = DATA_WIDTH'(signed'(din));
         r.status        = ST_ENQUEUED;
         return r;
      end
      if (int'(qid) >= NUM_QUEUES || int'(head_of[qid]) >= NUM_SLOTS) begin
         r.status   = ST_EMPTY;
         r.data_out = '1;
         return r;
      end
      slot            = head_of[qid];
      sidx            = slot[SLOT_W-1:0];
      head_of[qid]    = slot_next[sidx];
      slot_next[sidx] = free_slot;
      free_slot       = slot;
      r.status        = ST_DEQUEUED;
      r.data_out      = IO_DATA_W'(signed'(slot_word[sidx]));
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         clear_store();
         predicted_replies.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && req_ready)
            predicted_replies.push_back(apply_queue_op(req_cmd, req_queue_id, req_data_in));
         if (rsp_valid && rsp_ready) begin
            if (predicted_replies.size() == 0) begin
               $display("%0t: reply with none pending: status %0d data_out %h",
                        $time, rsp_status, rsp_data_out);
               mismatch_count++;
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_data_out !== want.data_out) begin
                  $display("%0t: data_out expected %h, actual %h",
                           $time, want.data_out, rsp_data_out);
                  mismatch_count++;
               end
            end
         end
      end
      outstanding = predicted_replies.size();
   end

endmodule

// ===== dv/tb_multi_queue_shared_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_queue_shared_buffer: testbench of the shared-buffer FIFO queues
// Drives enqueue and dequeue items with random gaps and reply back-pressure,
// first a directed sequence over the data extremes, empty and stale-tail
// cases, then random fill, drain and mixed phases that run the store full
// and empty many times. The scoreboard beside the block and the bound checker do the checking.
// ----------------------------------------------------------------------------
module tb_multi_queue_shared_buffer;
   import mqsb_pkg::*;

   localparam int TOTAL_ITEMS = 1775;

   logic                        clock        = 1'b0;
   logic                        reset        = 1'b1;
   logic                        req_valid    = 1'b0;
   logic                        req_ready;
   logic [CMD_W-1:0]            req_cmd      = CMD_ENQ;
   logic [QID_W-1:0]            req_queue_id = '0;
   logic signed [IO_DATA_W-1:0] req_data_in  = '0;
   logic                        rsp_valid;
   logic                        rsp_ready    = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic signed [IO_DATA_W-1:0] rsp_data_out;

   int mismatch_count;
   int outstanding;
   int items_sent = 0;
   bit no_idle    = 1'b0;   // set during phases that run back to back

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   multi_queue_shared_buffer uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_queue_id (req_queue_id),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out)
   );

   mqsb_scoreboard scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_queue_id   (req_queue_id),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // idle cycles before the next item on either side
   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   // bias toward the corner values of the data word
   function automatic logic [IO_DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // Enter and leave at a falling edge. Hold valid and payload until accepted;
   // keep valid high when no gap follows, so it is never dropped and raised
   // within one step.
   task automatic send_queue_op(input logic [CMD_W-1:0]     cmd,
                                input logic [QID_W-1:0]     qid,
                                input logic [IO_DATA_W-1:0] din);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_queue_id <= qid;
      req_data_in  <= din;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // reply side: stall a random number of cycles, then take one item
   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      logic [CMD_W-1:0] cmd;
      logic [QID_W-1:0] qid;
      int               enq_pct;
      int               focus;
      int               phase_len;
      int               drain;

      // hold reset, then release it at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty queue, data extremes, FIFO order, stale tail
      send_queue_op(CMD_DEQ, 3'd0, 32'h1234_5678);
      send_queue_op(CMD_ENQ, 3'd0, 32'h7FFF_FFFF);
      send_queue_op(CMD_ENQ, 3'd0, 32'h8000_0000);
      send_queue_op(CMD_ENQ, 3'd7, 32'h0000_0000);
      send_queue_op(CMD_ENQ, 3'd7, 32'hFFFF_FFFF);
      send_queue_op(CMD_DEQ, 3'd0, 32'h0);
      send_queue_op(CMD_DEQ, 3'd0, 32'hFFFF_FFFF);
      // queue 0 is drained now and keeps its old tail; this dequeue finds it empty
      send_queue_op(CMD_DEQ, 3'd0, 32'h0);
      send_queue_op(CMD_ENQ, 3'd0, 32'h5555_5555);
      send_queue_op(CMD_ENQ, 3'd0, 32'hAAAA_AAAA);
      send_queue_op(CMD_DEQ, 3'd7, 32'h0);
      send_queue_op(CMD_DEQ, 3'd7, 32'h0);
      send_queue_op(CMD_DEQ, 3'd7, 32'h0);
      send_queue_op(CMD_DEQ, 3'd0, 32'h0);
      send_queue_op(CMD_DEQ, 3'd0, 32'h0);
      for (int q = 1; q < 7; q++)
         send_queue_op(CMD_ENQ, QID_W'(q), pick_value());
      send_queue_op(CMD_DEQ, 3'd6, 32'h0);
      send_queue_op(CMD_DEQ, 3'd3, 32'h0);

      // random phases: fill toward full, drain toward empty, or mix;
      // half the items go to one focus queue so long chains form
      while (items_sent < TOTAL_ITEMS) begin
         phase_len = $urandom_range(8, 90);
         no_idle   = ($urandom_range(0, 3) == 0);
         focus     = $urandom_range(0, (1 << QID_W) - 1);
         case ($urandom_range(0, 2))
            0:       enq_pct = 90;
            1:       enq_pct = 15;
            default: enq_pct = 50;
         endcase
         repeat (phase_len) begin
            cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            qid = $urandom_range(0, 1) ? QID_W'(focus)
                                       : QID_W'($urandom_range(0, (1 << QID_W) - 1));
            send_queue_op(cmd, qid, pick_value());
         end
      end
      no_idle = 1'b0;

      // drop valid, wait for every reply, then let the pipeline settle
      req_valid <= 1'b0;
      drain = 0;
      while (outstanding != 0 && drain < 4000) begin
         @(negedge clock);
         drain++;
      end
      repeat (16) @(negedge clock);

      if (mismatch_count == 0 && outstanding == 0)
         $display("** multi_queue_shared_buffer: PASSED **");
      else
         $display("** multi_queue_shared_buffer: FAILED **");
      $finish;
   end

   // watchdog: end a hung run
   initial begin
      #2_000_000;
      $display("** multi_queue_shared_buffer: FAILED **");
      $finish;
   end

endmodule

// ===== multi_queue_shared_buffer.f =====
rtl/mqsb_pkg.sv
rtl/mqsb_ram.sv
rtl/mqsb_ctrl.sv
rtl/mqsb_datapath.sv
rtl/multi_queue_shared_buffer.sv
rtl/mqsb_checker.sv
dv/mqsb_scoreboard.sv
dv/tb_multi_queue_shared_buffer.sv
